// ===== rtl/tns_pkg.sv =====
// Shared types and constants of the tone note sequencer.
package tns_pkg;

   localparam logic [1:0] ACT_ADD_RAW   = 2'd0;
   localparam logic [1:0] ACT_ADD_TIMED = 2'd1;
   localparam logic [1:0] ACT_TICK      = 2'd2;

   localparam logic CSR_TEMPO = 1'b0;
   localparam logic CSR_DUTY  = 1'b1;

   localparam logic [9:0]  RESET_TEMPO   = 10'd100;
   localparam logic [9:0]  RESET_DUTY    = 10'd500;
   localparam logic [17:0] WHOLE_NOTE_MS = 18'd240000;
   localparam logic [9:0]  TIME_DIV      = 10'd10;

   // divider geometry: 22-bit dividend, 10-bit divisor, one quotient bit per cycle
   localparam int DIV_W  = 22;
   localparam int DVS_W  = 10;
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEPS_SHORT = 5'd18;
   localparam logic [STEP_W-1:0] STEPS_LONG  = 5'd22;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;   // left aligned: value << (DIV_W - steps)
      logic [DVS_W-1:0]  divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

endpackage

// ===== rtl/tns_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module tns_divider
   import tns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] count_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic [DIV_W-1:0]  dq_ff;

   logic [DVS_W:0]    shifted;
   logic [DVS_W:0]    diff;
   logic              q_bit;
   logic [DVS_W-1:0]  rem_in;
   logic [DIV_W-1:0]  dq_in;

   always_comb begin
      shifted = {rem_ff, dq_ff[DIV_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      q_bit   = (shifted >= {1'b0, dvs_ff});
      rem_in  = q_bit ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      dq_in   = {dq_ff[DIV_W-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= !div_req.start && busy_ff && (count_ff == STEP_W'(1));
         if (div_req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= div_req.steps;
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         dvs_ff <= div_req.divisor;
         dq_ff  <= div_req.dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dq_ff;

endmodule

// ===== rtl/tns_queue.sv =====
// Note FIFO: circular buffer memory with head, tail and fill count.
module tns_queue
   import tns_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  queue_ctl_type                queue_ctl,
   input  logic [31:0]                  wr_data,
   output logic [31:0]                  rd_data,
   output logic [$clog2(DEPTH+1)-1:0]   fill
);

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH+1);

   logic [31:0]       mem [DEPTH];
   logic [IDX_W-1:0]  head_ff;
   logic [IDX_W-1:0]  tail_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [31:0]       rd_data_ff;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] ptr);
      return (ptr == IDX_W'(DEPTH-1)) ? '0 : ptr + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (queue_ctl.push) begin
            tail_ff <= wrap_inc(tail_ff);
            fill_ff <= fill_ff + 1'b1;
         end else if (queue_ctl.pop) begin
            head_ff <= wrap_inc(head_ff);
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_ctl.push) begin
         mem[tail_ff] <= wr_data;
      end
      rd_data_ff <= mem[head_ff];
   end

   assign rd_data = rd_data_ff;
   assign fill    = fill_ff;

endmodule

// ===== rtl/tone_note_sequencer.sv =====
// Tone note sequencer: note queue, serial duration divider and tone output.
// add_raw, tick, unused codes and a zero-divider add_timed go from acceptance straight
// to ST_COMMIT, which loads the result once the output register is free.
// add_timed runs three serial divisions (18 + 18 + 22 quotient bits, one per cycle),
// in ST_DIV_WHOLE, ST_DIV_NOTE and ST_DIV_TIME, then loads its result from ST_COMMIT.
// One transaction at a time: next item accepted the cycle after the result is loaded.
// Reset is synchronous: silent, queue empty, tempo 100, duty 500; no clearing pass.
module tone_note_sequencer
   import tns_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic [15:0]       req_note_freq,
   input  logic [15:0]       req_delay_ms,
   input  logic signed [7:0] req_note_divider,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_accepted,
   output logic              rsp_tone_on,
   output logic [15:0]       rsp_tone_freq,
   output logic [9:0]        rsp_tone_level,
   output logic [4:0]        rsp_queued_count,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [9:0]        csr_wdata
);

   localparam int FILL_W = $clog2(QUEUE_DEPTH+1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_WHOLE,
      ST_DIV_NOTE,
      ST_DIV_TIME,
      ST_COMMIT
   } state_type;

   state_type         state_ff;
   logic [9:0]        tempo_ff;
   logic [9:0]        duty_ff;
   logic [1:0]        act_ff;
   logic              reject_ff;
   logic              dotted_ff;
   logic [7:0]        mag_ff;
   logic [15:0]       freq_ff;
   logic [15:0]       ms_ff;
   logic              playing_ff;
   logic [15:0]       cur_freq_ff;
   logic [15:0]       remain_ff;

   logic              rsp_valid_ff;
   logic              rsp_accepted_ff;
   logic              rsp_tone_on_ff;
   logic [15:0]       rsp_tone_freq_ff;
   logic [9:0]        rsp_tone_level_ff;
   logic [4:0]        rsp_queued_count_ff;

   div_req_type       div_req;
   div_rsp_type       div_rsp;
   queue_ctl_type     queue_ctl;
   logic [31:0]       q_rdata;
   logic [FILL_W-1:0] q_fill;

   logic              accept;
   logic              out_free;
   logic              commit;
   logic              is_add;
   logic              is_tick;
   logic              ok_in;
   logic              push_c;
   logic              pop_c;
   logic              playing_in;
   logic [15:0]       cur_freq_in;
   logic [15:0]       remain_in;
   logic [15:0]       rem_dec;
   logic [FILL_W-1:0] fill_in;
   logic [7:0]        mag_in;
   logic [18:0]       dot_len;
   logic [21:0]       scaled;
   logic [15:0]       time_sat;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == ST_COMMIT) && out_free;
   assign mag_in    = req_note_divider[7] ? 8'(-req_note_divider) : req_note_divider;

   // timed length: dotted adds half, then times nine for the 0.9 factor
   always_comb begin
      dot_len  = {1'b0, div_rsp.quotient[17:0]}
               + (dotted_ff ? {2'b0, div_rsp.quotient[17:1]} : 19'd0);
      scaled   = {dot_len, 3'b000} + {3'b000, dot_len};
      time_sat = (|div_rsp.quotient[21:16]) ? 16'hFFFF : div_rsp.quotient[15:0];
   end

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = {WHOLE_NOTE_MS, 4'b0000};
      div_req.divisor  = (tempo_ff == 10'd0) ? 10'd1 : tempo_ff;
      div_req.steps    = STEPS_SHORT;
      case (state_ff)
         ST_IDLE: begin
            div_req.start = accept && (req_action == ACT_ADD_TIMED)
                          && (req_note_divider != 8'sd0);
         end
         ST_DIV_WHOLE: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = {div_rsp.quotient[17:0], 4'b0000};
            div_req.divisor  = {2'b00, mag_ff};
         end
         ST_DIV_NOTE: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = scaled;
            div_req.divisor  = TIME_DIV;
            div_req.steps    = STEPS_LONG;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      is_add      = (act_ff == ACT_ADD_RAW) || ((act_ff == ACT_ADD_TIMED) && !reject_ff);
      is_tick     = (act_ff == ACT_TICK);
      rem_dec     = (remain_ff != 16'd0) ? remain_ff - 16'd1 : 16'd0;
      ok_in       = 1'b0;
      push_c      = 1'b0;
      pop_c       = 1'b0;
      playing_in  = playing_ff;
      cur_freq_in = cur_freq_ff;
      remain_in   = remain_ff;
      if (is_add) begin
         if (!playing_ff) begin
            ok_in       = 1'b1;
            playing_in  = 1'b1;
            cur_freq_in = freq_ff;
            remain_in   = ms_ff;
         end else if (q_fill != FILL_W'(QUEUE_DEPTH)) begin
            ok_in  = 1'b1;
            push_c = 1'b1;
         end
      end else if (is_tick && playing_ff) begin
         remain_in = rem_dec;
         if (rem_dec == 16'd0) begin
            if (q_fill != '0) begin
               // head of queue starts at once, not counted down by this tick
               pop_c       = 1'b1;
               cur_freq_in = q_rdata[31:16];
               remain_in   = q_rdata[15:0];
            end else begin
               playing_in  = 1'b0;
               cur_freq_in = 16'd0;
            end
         end
      end
      if (push_c) begin
         fill_in = q_fill + 1'b1;
      end else if (pop_c) begin
         fill_in = q_fill - 1'b1;
      end else begin
         fill_in = q_fill;
      end
      queue_ctl.push = commit && push_c;
      queue_ctl.pop  = commit && pop_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tempo_ff     <= RESET_TEMPO;
         duty_ff      <= RESET_DUTY;
         playing_ff   <= 1'b0;
         cur_freq_ff  <= 16'd0;
         remain_ff    <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_TEMPO: tempo_ff <= csr_wdata;
               CSR_DUTY:  duty_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && !commit) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (div_req.start) begin
                     state_ff <= ST_DIV_WHOLE;
                  end else begin
                     state_ff <= ST_COMMIT;
                  end
               end
            end
            ST_DIV_WHOLE: begin
               if (div_rsp.done) state_ff <= ST_DIV_NOTE;
            end
            ST_DIV_NOTE: begin
               if (div_rsp.done) state_ff <= ST_DIV_TIME;
            end
            ST_DIV_TIME: begin
               if (div_rsp.done) state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (out_free) begin
                  state_ff            <= ST_IDLE;
                  playing_ff          <= playing_in;
                  cur_freq_ff         <= cur_freq_in;
                  remain_ff           <= remain_in;
                  rsp_valid_ff        <= 1'b1;
                  rsp_accepted_ff     <= ok_in;
                  rsp_tone_on_ff      <= playing_in;
                  rsp_tone_freq_ff    <= playing_in ? cur_freq_in : 16'd0;
                  rsp_tone_level_ff   <= playing_in ? duty_ff : 10'd0;
                  rsp_queued_count_ff <= 5'(fill_in);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // transaction fields; payload registers carry no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff    <= req_action;
         reject_ff <= (req_note_divider == 8'sd0);
         dotted_ff <= req_note_divider[7];
         mag_ff    <= mag_in;
         freq_ff   <= req_note_freq;
         ms_ff     <= req_delay_ms;
      end else if ((state_ff == ST_DIV_TIME) && div_rsp.done) begin
         ms_ff <= time_sat;
      end
   end

   tns_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   tns_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .queue_ctl (queue_ctl),
      .wr_data   ({freq_ff, ms_ff}),
      .rd_data   (q_rdata),
      .fill      (q_fill)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_tone_on      = rsp_tone_on_ff;
   assign rsp_tone_freq    = rsp_tone_freq_ff;
   assign rsp_tone_level   = rsp_tone_level_ff;
   assign rsp_queued_count = rsp_queued_count_ff;

endmodule

// ===== rtl/tns_checker.sv =====
// Port-level checks of the tone note sequencer, bound to the top level.
module tns_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_accepted,
   input logic        rsp_tone_on,
   input logic [15:0] rsp_tone_freq,
   input logic [9:0]  rsp_tone_level,
   input logic [4:0]  rsp_queued_count
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_accepted) && $stable(rsp_tone_on)
         && $stable(rsp_tone_freq) && $stable(rsp_queued_count))
      else $error("result changed while stalled");

   // silent output carries no frequency and no level
   a_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tone_on |-> rsp_tone_freq == 16'd0 && rsp_tone_level == 10'd0)
      else $error("tone fields set while silent");

   // the queue drains into the tone, so silence means an empty queue
   a_silent_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tone_on |-> rsp_queued_count == 5'd0)
      else $error("notes queued while silent");

   // one transaction at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("new transaction taken while busy");

endmodule

bind tone_note_sequencer tns_checker u_tns_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_accepted     (rsp_accepted),
   .rsp_tone_on      (rsp_tone_on),
   .rsp_tone_freq    (rsp_tone_freq),
   .rsp_tone_level   (rsp_tone_level),
   .rsp_queued_count (rsp_queued_count)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the tone note sequencer: random note traffic against a predictor.
module tb_top;
   import tns_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 80;    // longer than the add_timed latency
   localparam int HOLD_AFTER = 200;      // results seen before the long receiver hold-off
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_PRINTED = 50;

   typedef struct packed {
      logic [1:0]        action;
      logic [15:0]       freq;
      logic [15:0]       delay;
      logic signed [7:0] divider;
   } note_cmd_type;

   typedef struct packed {
      logic        accepted;
      logic        tone_on;
      logic [15:0] freq;
      logic [9:0]  level;
      logic [4:0]  count;
   } tone_snapshot_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_action = '0;
   logic [15:0]       req_note_freq = '0;
   logic [15:0]       req_delay_ms = '0;
   logic signed [7:0] req_note_divider = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_accepted;
   logic              rsp_tone_on;
   logic [15:0]       rsp_tone_freq;
   logic [9:0]        rsp_tone_level;
   logic [4:0]        rsp_queued_count;
   logic              csr_write = 1'b0;
   logic              csr_index = 1'b0;
   logic [9:0]        csr_wdata = '0;

   // predicted sequencer state
   logic [31:0]    waiting_notes[$];
   logic           sounding = 1'b0;
   logic [15:0]    sound_freq = '0;
   logic [15:0]    ms_left = '0;
   logic [9:0]     tempo = RESET_TEMPO;
   logic [9:0]     duty = RESET_DUTY;

   note_cmd_type      pending_cmds[$];
   tone_snapshot_type expected_snapshots[$];
   note_cmd_type      cur_cmd;
   tone_snapshot_type want;
   int             error_count = 0;
   int             burst_left = 0;
   int             gap_left = 0;
   int             idle_cycles = 0;
   int             results_taken = 0;
   int             hold_left = 0;
   bit             hold_done = 1'b0;
   int             mode_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   tone_note_sequencer #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_note_freq(req_note_freq),
      .req_delay_ms(req_delay_ms),
      .req_note_divider(req_note_divider),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_accepted(rsp_accepted),
      .rsp_tone_on(rsp_tone_on),
      .rsp_tone_freq(rsp_tone_freq),
      .rsp_tone_level(rsp_tone_level),
      .rsp_queued_count(rsp_queued_count),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------- predictor ----------------

   function automatic logic [15:0] note_length_ms(logic signed [7:0] divider);
      int unsigned beats, whole, mag, len;
      int sdiv;
      sdiv = divider;
      beats = (tempo == 0) ? 1 : tempo;
      whole = WHOLE_NOTE_MS / beats;
      mag = (sdiv < 0) ? -sdiv : sdiv;
      len = whole / mag;
      if (sdiv < 0) len = len + len / 2;   // dotted
      len = len * 9 / 10;
      return (len > 65535) ? 16'hFFFF : 16'(len);
   endfunction

   function automatic logic queue_note(logic [15:0] f, logic [15:0] ms);
      if (!sounding) begin
         sounding = 1'b1;
         sound_freq = f;
         ms_left = ms;
         return 1'b1;
      end
      if (waiting_notes.size() >= QUEUE_DEPTH) return 1'b0;
      waiting_notes.push_back({f, ms});
      return 1'b1;
   endfunction

   function automatic tone_snapshot_type apply_note_cmd(note_cmd_type cmd);
      logic              ok;
      logic [31:0]       head;
      tone_snapshot_type snap;
      ok = 1'b0;
      case (cmd.action)
         ACT_ADD_RAW: ok = queue_note(cmd.freq, cmd.delay);
         ACT_ADD_TIMED: if (cmd.divider != 0) ok = queue_note(cmd.freq, note_length_ms(cmd.divider));
         ACT_TICK: if (sounding) begin
            if (ms_left != 0) ms_left--;
            if (ms_left == 0) begin
               sounding = 1'b0;
               sound_freq = '0;
               // next note starts with its full time, not counted down by this tick
               if (waiting_notes.size() != 0) begin
                  head = waiting_notes.pop_front();
                  sounding = 1'b1;
                  sound_freq = head[31:16];
                  ms_left = head[15:0];
               end
            end
         end
         default: ;
      endcase
      snap.accepted = ok;
      snap.tone_on = sounding;
      snap.freq = sounding ? sound_freq : '0;
      snap.level = sounding ? duty : '0;
      snap.count = 5'(waiting_notes.size());
      return snap;
   endfunction

   // ---------------- stimulus ----------------

   function automatic void push_cmd(logic [1:0] act, logic [15:0] f, logic [15:0] ms,
                                    logic signed [7:0] dv);
      note_cmd_type c;
      c.action = act;
      c.freq = f;
      c.delay = ms;
      c.divider = dv;
      pending_cmds.push_back(c);
   endfunction

   // divider giving a short note at the current tempo; zero (a reject) if none is found
   function automatic logic signed [7:0] short_divider();
      int v;
      repeat (8) begin
         v = int'($urandom_range(0, 128)) - 64;
         if (v != 0 && note_length_ms(8'(v)) <= 40) return 8'(v);
      end
      return 8'sd0;
   endfunction

   function automatic void add_random_cmds(int unsigned n, bit long_ok);
      int unsigned made, k, ticks, len, pick;
      logic [1:0]        act;
      logic [15:0]       ms;
      logic signed [7:0] dv;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(0, 99);
         if (pick < (long_ok ? 50 : 15)) begin
            act = 2'($urandom_range(0, 3));
            ms = long_ok ? 16'($urandom) : 16'($urandom_range(0, 6));
            dv = long_ok ? 8'($urandom) : short_divider();
            push_cmd(act, 16'($urandom), ms, dv);
            if (act != ACT_UNUSED) made++;
         end else if (pick < (long_ok ? 60 : 25)) begin
            // push the queue depth plus up to four notes, which can overrun it, then drain it
            k = $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 4);
            repeat (k) push_cmd(ACT_ADD_RAW, 16'($urandom), 16'($urandom_range(0, 1)), 8'($urandom));
            repeat (k + 3) push_cmd(ACT_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
            made += 2 * k + 3;
         end else begin
            // short tune, followed by roughly enough ticks to play it
            k = $urandom_range(1, 6);
            ticks = 0;
            repeat (k) begin
               if ($urandom_range(0, 9) < 6) begin
                  len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
                  push_cmd(ACT_ADD_RAW, 16'($urandom), 16'(len), 8'($urandom));
               end else begin
                  dv = short_divider();
                  len = (dv == 0) ? 0 : note_length_ms(dv);
                  push_cmd(ACT_ADD_TIMED, 16'($urandom), 16'($urandom), dv);
               end
               ticks += len + 1;
            end
            ticks = $urandom_range(ticks / 2, ticks + 2);
            repeat (ticks) push_cmd(ACT_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
            made += k + ticks;
         end
      end
   endfunction

   task automatic write_reg(logic idx, logic [9:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_TEMPO) tempo = value;
      else duty = value;
   endtask

   // wait until every transaction is sent and answered, then let the block go quiet
   task automatic settle();
      while (pending_cmds.size() != 0 || req_valid || expected_snapshots.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_error(string msg);
      if (error_count < MAX_PRINTED) $display("%0t ERROR %s", $realtime, msg);
      error_count++;
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_snapshots.push_back(apply_note_cmd(cur_cmd));
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            cur_cmd = pending_cmds.pop_front();
            req_valid <= 1'b1;
            req_action <= cur_cmd.action;
            req_note_freq <= cur_cmd.freq;
            req_delay_ms <= cur_cmd.delay;
            req_note_divider <= cur_cmd.divider;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- receiver stall pattern ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) results_taken++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && results_taken >= HOLD_AFTER) begin
            // one long hold-off so the block backs up onto its input
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
               STALL_NONE: rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_snapshots.size() == 0) begin
            report_error("result with no transaction outstanding");
         end else begin
            want = expected_snapshots.pop_front();
            if (rsp_accepted !== want.accepted)
               report_error($sformatf("accepted got %0h want %0h", rsp_accepted, want.accepted));
            if (rsp_tone_on !== want.tone_on)
               report_error($sformatf("tone_on got %0h want %0h", rsp_tone_on, want.tone_on));
            if (rsp_tone_freq !== want.freq)
               report_error($sformatf("tone_freq got %0h want %0h", rsp_tone_freq, want.freq));
            if (rsp_tone_level !== want.level)
               report_error($sformatf("tone_level got %0h want %0h", rsp_tone_level, want.level));
            if (rsp_queued_count !== want.count)
               report_error($sformatf("queued_count got %0h want %0h",
                                      rsp_queued_count, want.count));
         end
      end
   end

   // ---------------- watchdog ----------------

   always @(posedge clock) begin
      if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------- test sequence ----------------

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset tempo and duty: idle cases, zero divider, zero delay, divider extremes
      push_cmd(ACT_TICK, 16'h0000, 16'h0000, 8'sd0);
      push_cmd(ACT_UNUSED, 16'hFFFF, 16'hFFFF, -8'sd1);
      push_cmd(ACT_ADD_TIMED, 16'h1234, 16'h0000, 8'sd0);
      push_cmd(ACT_ADD_RAW, 16'h0000, 16'h0000, 8'sd0);
      push_cmd(ACT_ADD_RAW, 16'hFFFF, 16'h0002, 8'sd127);
      push_cmd(ACT_ADD_TIMED, 16'h1234, 16'h0000, 8'sd127);
      push_cmd(ACT_ADD_TIMED, 16'hA5A5, 16'h0000, -8'sd128);
      push_cmd(ACT_ADD_TIMED, 16'h5A5A, 16'h00FF, 8'sd0);
      push_cmd(ACT_UNUSED, 16'h0001, 16'h0001, 8'sd1);
      push_cmd(ACT_TICK, 16'hFFFF, 16'hFFFF, -8'sd128);
      push_cmd(ACT_TICK, 16'h0000, 16'h0000, 8'sd0);
      push_cmd(ACT_TICK, 16'h0000, 16'h0000, 8'sd0);
      push_cmd(ACT_TICK, 16'h0000, 16'h0000, 8'sd0);
      add_random_cmds(100, 1'b0);
      settle();

      write_reg(CSR_TEMPO, 10'd1000);
      write_reg(CSR_DUTY, 10'd1023);
      add_random_cmds(110, 1'b0);
      settle();

      write_reg(CSR_TEMPO, 10'd1023);
      write_reg(CSR_DUTY, 10'd0);
      add_random_cmds(100, 1'b0);
      settle();

      write_reg(CSR_TEMPO, 10'($urandom_range(150, 999)));
      write_reg(CSR_DUTY, 10'($urandom));
      add_random_cmds(110, 1'b0);
      settle();

      write_reg(CSR_TEMPO, 10'd250);
      write_reg(CSR_DUTY, 10'($urandom));
      add_random_cmds(100, 1'b0);
      settle();

      // slow tempos last: their notes are long enough to keep the queue full
      write_reg(CSR_TEMPO, 10'd0);
      write_reg(CSR_DUTY, 10'd1);
      push_cmd(ACT_ADD_TIMED, 16'h8001, 16'h0000, 8'sd64);
      push_cmd(ACT_ADD_TIMED, 16'h7FFE, 16'h0000, -8'sd64);
      add_random_cmds(60, 1'b1);
      settle();

      write_reg(CSR_TEMPO, 10'd1);
      write_reg(CSR_DUTY, 10'd1022);
      push_cmd(ACT_ADD_RAW, 16'hFFFF, 16'hFFFF, 8'sd0);
      push_cmd(ACT_ADD_TIMED, 16'h0100, 16'h0000, 8'sd1);
      push_cmd(ACT_ADD_TIMED, 16'h0200, 16'h0000, -8'sd1);
      push_cmd(ACT_TICK, 16'h0000, 16'h0000, 8'sd0);
      add_random_cmds(90, 1'b1);
      settle();

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
